// ===== hw/rtl/lrd_pkg.sv =====
// Package: constants and types for the log record deframer.
package lrd_pkg;

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_CRC  = 3'd1,
        PH_HEAD = 3'd2,
        PH_KLEN = 3'd3,
        PH_KEY  = 3'd4,
        PH_VLEN = 3'd5,
        PH_VAL  = 3'd6,
        PH_TAIL = 3'd7
    } phase_t;

    localparam logic [2:0] ST_ENTRY    = 3'd0;
    localparam logic [2:0] ST_META     = 3'd1;
    localparam logic [2:0] ST_OTHER    = 3'd2;
    localparam logic [2:0] ST_CLEAN    = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_OVERSIZE = 3'd5;
    localparam logic [2:0] ST_CRCBAD   = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;

    localparam logic [1:0] CMD_NOP = 2'd0;
    localparam logic [1:0] CMD_PUT = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [31:0] MAX_LEN_RESET    = 32'h0400_0000;
    localparam logic [7:0]  ENTRY_CODE_RESET = 8'd1;
    localparam logic [7:0]  META_CODE_RESET  = 8'd2;

    localparam logic [3:0] REG_MAX_LEN    = 4'h0;
    localparam logic [3:0] REG_ENTRY_CODE = 4'h4;
    localparam logic [3:0] REG_META_CODE  = 4'h8;

    // Result word, fields listed from high to low in tdata order.
    typedef struct packed {
        logic [31:0] payload_length;
        logic [31:0] vote_node;
        logic        vote_present;
        logic [31:0] value_length;
        logic [31:0] key_length;
        logic [1:0]  command_kind;
        logic [63:0] entry_term;
        logic [63:0] entry_index;
        logic        at_end;
        logic [2:0]  status;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/log_record_deframer_crc32.sv =====
// Top level: byte-stream log record deframer with CRC-32 check.
//
// Takes one file byte per transaction on the s_ stream (tdata = data_byte,
// tlast = is_last) and returns at most one result per byte on the m_ stream.
// Each byte is processed combinationally: the byte-wise CRC-32 update and the
// field shifts sit between the input handshake and the result register, so
// a byte is accepted every cycle while the result register is empty or is
// being drained. A byte's result shows on m_ in the cycle after it is accepted.
// A torn tail (short, oversize, CRC bad, empty) halts the block until reset;
// while halted bytes are still accepted and dropped. Registers: 0x0
// max_record_length, 0x4 log_entry_code, 0x8 metadata_code.
module log_record_deframer_crc32 (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // is_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [3] at_end, [67:4] entry_index, [131:68] entry_term,
    // [133:132] command_kind, [165:134] key_length, [197:166] value_length,
    // [198] vote_present, [230:199] vote_node, [262:231] payload_length, pad 0
    output logic [263:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lrd_pkg::*;

    logic [31:0] max_len_reg;
    logic [7:0]  entry_code_reg, meta_code_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fcnt_reg, fcnt_next;
    logic [31:0] rlen_reg, rlen_next;
    logic [31:0] scrc_reg, scrc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [31:0] pcnt_reg, pcnt_next;
    logic [7:0]  rtype_reg, rtype_next;
    logic [63:0] index_reg, index_next;
    logic [63:0] term_reg, term_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [31:0] klen_reg, klen_next;
    logic [31:0] vlen_reg, vlen_next;
    logic [31:0] srem_reg, srem_next;
    logic        vflag_reg, vflag_next;
    logic [31:0] vote_reg, vote_next;
    logic        halted_reg, halted_next;

    logic        out_valid_reg;
    result_t     out_reg, res;
    logic        emit;
    logic [2:0]  status;
    logic        accept;

    assign pready   = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    always_comb begin
        case (paddr)
            REG_MAX_LEN:    prdata = max_len_reg;
            REG_ENTRY_CODE: prdata = {24'd0, entry_code_reg};
            REG_META_CODE:  prdata = {24'd0, meta_code_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            entry_code_reg <= ENTRY_CODE_RESET;
            meta_code_reg  <= META_CODE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                REG_MAX_LEN:    max_len_reg <= pwdata;
                REG_ENTRY_CODE: entry_code_reg <= pwdata[7:0];
                REG_META_CODE:  meta_code_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Per-byte parse; the "finish" check uses the CRC and type after this byte.
    always_comb begin
        logic [31:0] bw, pos, crc_new;
        logic        ent, meta, done, kdone;
        logic [4:0]  sh;
        bw = {24'd0, s_tdata};
        phase_next = phase_reg; fcnt_next = fcnt_reg; rlen_next = rlen_reg;
        scrc_next = scrc_reg; rcrc_next = rcrc_reg; pcnt_next = pcnt_reg;
        rtype_next = rtype_reg; index_next = index_reg; term_next = term_reg;
        cmd_next = cmd_reg; klen_next = klen_reg; vlen_next = vlen_reg;
        srem_next = srem_reg; vflag_next = vflag_reg; vote_next = vote_reg;
        halted_next = halted_reg;
        done = 1'b0; status = ST_ENTRY; kdone = 1'b0;
        pos = pcnt_reg;
        sh = {fcnt_reg, 3'b000};
        ent = (rtype_reg == entry_code_reg);
        meta = !ent && (rtype_reg == meta_code_reg);
        crc_new = crc_byte(rcrc_reg, s_tdata);

        case (phase_reg)
            PH_LEN: begin
                rlen_next = rlen_reg | (bw << sh);
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd3) phase_next = PH_CRC;
            end
            PH_CRC: begin
                scrc_next = scrc_reg | (bw << sh);
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd3) begin
                    phase_next = PH_HEAD;
                    if (rlen_reg > max_len_reg) begin
                        done = 1'b1; status = ST_OVERSIZE;
                    end else if (rlen_reg == 32'd0) begin
                        done = 1'b1;
                        status = (scrc_next != 32'd0) ? ST_CRCBAD : ST_EMPTY;
                    end
                end
            end
            default: begin
                rcrc_next = crc_new;
                pcnt_next = pcnt_reg + 32'd1;
                case (phase_reg)
                    PH_HEAD: begin
                        if (pos == 32'd0) begin
                            rtype_next = s_tdata;
                        end else if (ent) begin
                            if (pos <= 32'd8)
                                index_next = index_reg |
                                    ({56'd0, s_tdata} << {pos[2:0] - 3'd1, 3'b000});
                            else if (pos <= 32'd16)
                                term_next = term_reg |
                                    ({56'd0, s_tdata} << {pos[2:0] - 3'd1, 3'b000});
                            else begin
                                cmd_next = (s_tdata == {6'd0, CMD_PUT}) ? CMD_PUT :
                                           (s_tdata == {6'd0, CMD_DEL}) ? CMD_DEL : CMD_NOP;
                                fcnt_next = 2'd0;
                                phase_next = (cmd_next != CMD_NOP) ? PH_KLEN : PH_TAIL;
                            end
                        end else if (meta) begin
                            if (pos <= 32'd8)
                                term_next = term_reg |
                                    ({56'd0, s_tdata} << {pos[2:0] - 3'd1, 3'b000});
                            else if (pos == 32'd9)
                                vflag_next = (s_tdata != 8'd0);
                            else if (pos <= 32'd13 && vflag_reg)
                                vote_next = vote_reg | (bw << {pos[1:0] - 2'd2, 3'b000});
                        end
                    end
                    PH_KLEN: begin
                        klen_next = klen_reg | (bw << sh);
                        fcnt_next = fcnt_reg + 2'd1;
                        if (fcnt_reg == 2'd3) begin
                            srem_next = klen_next;
                            if (klen_next != 32'd0) phase_next = PH_KEY;
                            else kdone = 1'b1;
                        end
                    end
                    PH_KEY: begin
                        srem_next = srem_reg - 32'd1;
                        if (srem_reg == 32'd1) kdone = 1'b1;
                    end
                    PH_VLEN: begin
                        vlen_next = vlen_reg | (bw << sh);
                        fcnt_next = fcnt_reg + 2'd1;
                        if (fcnt_reg == 2'd3) begin
                            srem_next = vlen_next;
                            phase_next = (vlen_next != 32'd0) ? PH_VAL : PH_TAIL;
                        end
                    end
                    PH_VAL: begin
                        srem_next = srem_reg - 32'd1;
                        if (srem_reg == 32'd1) phase_next = PH_TAIL;
                    end
                    default: ;
                endcase
                if (kdone) begin
                    fcnt_next = 2'd0;
                    phase_next = (cmd_reg == CMD_PUT) ? PH_VLEN : PH_TAIL;
                end
                if (pcnt_next == rlen_reg) begin
                    done = 1'b1;
                    if ((crc_new ^ CRC_ONES) != scrc_reg) status = ST_CRCBAD;
                    else if (rtype_next == entry_code_reg) status = ST_ENTRY;
                    else if (rtype_next == meta_code_reg) status = ST_META;
                    else status = ST_OTHER;
                end
            end
        endcase

        if (!done && s_tlast) status = ST_SHORT;
        emit = done || s_tlast;

        res.status         = status;
        res.at_end         = s_tlast;
        res.entry_index    = (status == ST_ENTRY) ? index_next : 64'd0;
        res.entry_term     = (status == ST_ENTRY || status == ST_META) ? term_next : 64'd0;
        res.command_kind   = (status == ST_ENTRY) ? cmd_next : CMD_NOP;
        res.key_length     = (status == ST_ENTRY) ? klen_next : 32'd0;
        res.value_length   = (status == ST_ENTRY) ? vlen_next : 32'd0;
        res.vote_present   = (status == ST_META) && vflag_next;
        res.vote_node      = (status == ST_META && vflag_next) ? vote_next : 32'd0;
        res.payload_length = (status == ST_SHORT) ? 32'd0 : rlen_next;

        if (status == ST_OVERSIZE || status == ST_CRCBAD || status == ST_EMPTY ||
            status == ST_SHORT) begin
            if (emit) halted_next = 1'b1;
        end
        if (emit) begin
            phase_next = PH_LEN; fcnt_next = 2'd0; rlen_next = 32'd0;
            scrc_next = 32'd0; rcrc_next = CRC_ONES; pcnt_next = 32'd0;
            rtype_next = 8'd0; index_next = 64'd0; term_next = 64'd0;
            cmd_next = CMD_NOP; klen_next = 32'd0; vlen_next = 32'd0;
            srem_next = 32'd0; vflag_next = 1'b0; vote_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN; fcnt_reg <= 2'd0; rlen_reg <= 32'd0;
            scrc_reg <= 32'd0; rcrc_reg <= CRC_ONES; pcnt_reg <= 32'd0;
            rtype_reg <= 8'd0; index_reg <= 64'd0; term_reg <= 64'd0;
            cmd_reg <= CMD_NOP; klen_reg <= 32'd0; vlen_reg <= 32'd0;
            srem_reg <= 32'd0; vflag_reg <= 1'b0; vote_reg <= 32'd0;
            halted_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else begin
            if (accept && !halted_reg) begin
                phase_reg <= phase_next; fcnt_reg <= fcnt_next; rlen_reg <= rlen_next;
                scrc_reg <= scrc_next; rcrc_reg <= rcrc_next; pcnt_reg <= pcnt_next;
                rtype_reg <= rtype_next; index_reg <= index_next; term_reg <= term_next;
                cmd_reg <= cmd_next; klen_reg <= klen_next; vlen_reg <= vlen_next;
                srem_reg <= srem_next; vflag_reg <= vflag_next; vote_reg <= vote_next;
                halted_reg <= halted_next;
            end
            // a new result wins over the drain of the old one
            if (accept && !halted_reg && emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !halted_reg && emit) out_reg <= res;
    end

endmodule

// ===== hw/rtl/lrd_checker.sv =====
// Checker: port-level assertions for the log record deframer, with bind.
module lrd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [263:0] m_tdata,
    input logic         pready
);
    import lrd_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[263] == 1'b0)
        else $error("pad bit set");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != ST_CLEAN)
        else $error("clean end status produced");
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind log_record_deframer_crc32 lrd_checker u_lrd_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
